// ----- sv/bbb_pkg.sv -----
// bbb_pkg: shared codes, widths and types of the boundary bisection binner
// used by bbb_cell and boundary_bisection_binner; depends on nothing else
package bbb_pkg;

    // input item modes
    localparam logic [1:0] MODE_WRITE    = 2'd0;
    localparam logic [1:0] MODE_CLASSIFY = 2'd1;
    localparam logic [1:0] MODE_CLEAR    = 2'd2;

    // fixed field widths
    localparam int CFG_BITS   = 7;
    localparam int WIDX_BITS  = 6;
    localparam int BIN_BITS   = 6;
    localparam int ID_BITS    = 16;
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // cells are read back in groups of eight
    localparam int GROUP_BITS = 3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_CHECK,
        ST_SEARCH,
        ST_FETCH,
        ST_PICK,
        ST_DONE
    } t_state;

    // strobes broadcast to every cell
    typedef struct packed {
        logic wr;
        logic clr;
        logic inc;
    } t_cell_cmd;

    // registered compare flags of one cell
    typedef struct packed {
        logic ge;
        logic le;
    } t_cell_flags;

endpackage

// ----- sv/boundary_bisection_binner.sv -----
// boundary_bisection_binner: top level with the row of cells and the bisection sequencer
// depends on bbb_pkg and bbb_cell
//
// A write item loads one boundary entry and a clear item zeroes every bin count. A
// classify item runs a bisection over the n active boundaries and skips it when the
// position is out of range. All cells compare the position in parallel, the sequencer
// then steps the bisection once per cycle over the compare flags, and the bin count is
// read back through a registered group select before the count is bumped. One item is
// in work at a time; a finished result waits in the output register while the next item
// is taken. No clearing pass after reset is needed.
module boundary_bisection_binner #(
    parameter int MAX_BOUNDARIES = 64,
    parameter int POSITION_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [bbb_pkg::CFG_BITS-1:0]      i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_mode,
    input  logic [bbb_pkg::WIDX_BITS-1:0]     i_boundary_index,
    input  logic signed [POSITION_BITS-1:0]   i_boundary_value,
    input  logic signed [POSITION_BITS-1:0]   i_position,
    input  logic [bbb_pkg::ID_BITS-1:0]       i_particle_id,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_in_range,
    output logic [bbb_pkg::BIN_BITS-1:0]      o_bin,
    output logic [bbb_pkg::COUNT_BITS-1:0]    o_slot,
    output logic                              o_bin_full,
    output logic [bbb_pkg::ID_BITS-1:0]       o_id_out
);
    import bbb_pkg::*;

    localparam int IW    = ($clog2(MAX_BOUNDARIES) > GROUP_BITS + 1) ?
                           $clog2(MAX_BOUNDARIES) : GROUP_BITS + 1;
    localparam int DEPTH = 2 ** IW;
    localparam int GW    = IW - GROUP_BITS;
    localparam int NG    = 2 ** GW;

    t_state                          r_state;
    t_state                          n_state;
    logic [CFG_BITS-1:0]             r_bcount;
    logic signed [POSITION_BITS-1:0] r_pos;
    logic [ID_BITS-1:0]              r_id;
    logic [IW-1:0]                   r_lo;
    logic [IW-1:0]                   r_hi;
    logic                            r_in_range;
    logic [COUNT_BITS-1:0]           r_grp [NG];
    logic [COUNT_BITS-1:0]           r_cnt;
    logic                            r_out_valid;
    logic                            r_out_in_range;
    logic [BIN_BITS-1:0]             r_out_bin;
    logic [COUNT_BITS-1:0]           r_out_slot;
    logic                            r_out_full;
    logic [ID_BITS-1:0]              r_out_id;

    logic                            w_in_accept;
    logic                            w_out_free;
    logic                            w_in_ready;
    logic                            w_fsm_inc;
    logic [IW-1:0]                   w_last;
    logic                            w_in_range;
    logic [IW:0]                     w_sum;
    logic [IW-1:0]                   w_mid;
    logic                            w_span_gt1;
    t_cell_cmd                       w_cmd;
    logic [DEPTH-1:0]                w_ge;
    logic [DEPTH-1:0]                w_le;
    logic [COUNT_BITS-1:0]           w_cnt [DEPTH];

    assign w_in_accept = i_in_valid && w_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // strobes to the row of cells
    assign w_cmd.wr  = w_in_accept && (i_mode == MODE_WRITE);
    assign w_cmd.clr = w_in_accept && (i_mode == MODE_CLEAR);
    assign w_cmd.inc = w_fsm_inc;

    // row of cells, padded with empty places up to a power of two
    for (genvar k = 0; k < DEPTH; k++) begin : g_cells
        if (k < MAX_BOUNDARIES) begin : g_used
            t_cell_flags w_flags;
            bbb_cell #(
                .POSITION_BITS (POSITION_BITS),
                .SEL_BITS      (IW),
                .INDEX         (k)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_cmd),
                .i_wr_idx  (i_boundary_index),
                .i_wr_data (i_boundary_value),
                .i_pos     (r_pos),
                .i_sel     (r_lo),
                .o_flags   (w_flags),
                .o_count   (w_cnt[k])
            );
            assign w_ge[k] = w_flags.ge;
            assign w_le[k] = w_flags.le;
        end else begin : g_pad
            assign w_ge[k]  = 1'b0;
            assign w_le[k]  = 1'b0;
            assign w_cnt[k] = '0;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount <= CFG_BITS'(2);
        end else if (i_cfg_we) begin
            r_bcount <= i_cfg_data;
        end
    end

    // last active boundary index, count clamped between 2 and the table size
    always_comb begin
        if (r_bcount < CFG_BITS'(2)) begin
            w_last = IW'(1);
        end else if (int'(r_bcount) > MAX_BOUNDARIES) begin
            w_last = IW'(MAX_BOUNDARIES - 1);
        end else begin
            w_last = IW'(r_bcount - CFG_BITS'(1));
        end
    end

    assign w_in_range = w_ge[0] && w_le[w_last];
    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[IW:1];
    assign w_span_gt1 = (r_hi - r_lo) > IW'(1);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept && (i_mode == MODE_CLASSIFY)) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP:    n_state = ST_CHECK;
            ST_CHECK:  n_state = w_in_range ? ST_SEARCH : ST_DONE;
            ST_SEARCH: n_state = w_span_gt1 ? ST_SEARCH : ST_FETCH;
            ST_FETCH:  n_state = ST_PICK;
            ST_PICK:   n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_fsm_inc  = 1'b0;
        unique case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_DONE: w_fsm_inc  = w_out_free && r_in_range && (r_cnt != COUNT_MAX);
            default: begin
                w_in_ready = 1'b0;
                w_fsm_inc  = 1'b0;
            end
        endcase
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_in_accept && (i_mode == MODE_CLASSIFY)) begin
            r_pos <= i_position;
            r_id  <= i_particle_id;
        end
    end

    // range check and bisection steps
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK) begin
            r_in_range <= w_in_range;
            r_lo       <= '0;
            r_hi       <= w_last;
        end else if ((r_state == ST_SEARCH) && w_span_gt1) begin
            if (w_ge[w_mid]) begin
                r_lo <= w_mid;
            end else begin
                r_hi <= w_mid;
            end
        end
    end

    // count read-back: pick within each group, then pick the group
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FETCH) begin
            for (int g = 0; g < NG; g++) begin
                r_grp[g] <= w_cnt[{GW'(g), r_lo[GROUP_BITS-1:0]}];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK) begin
            r_cnt <= '0;
        end else if (r_state == ST_PICK) begin
            r_cnt <= r_grp[r_lo[IW-1:GROUP_BITS]];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_in_range <= r_in_range;
            r_out_bin      <= BIN_BITS'(r_lo);
            r_out_slot     <= r_cnt;
            r_out_full     <= (r_cnt == COUNT_MAX);
            r_out_id       <= r_id;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_range  = r_out_in_range;
    assign o_bin       = r_out_bin;
    assign o_slot      = r_out_slot;
    assign o_bin_full  = r_out_full;
    assign o_id_out    = r_out_id;

    // an out of range item reports bin and slot as zero
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_range) |-> ((o_bin == '0) && (o_slot == '0) && !o_bin_full))
        else $error("out of range item with nonzero bin or slot");

    // a full flag only comes with a saturated slot
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bin_full) |-> (o_slot == COUNT_MAX))
        else $error("bin full without saturated slot");

    // the bisection interval never collapses
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_lo < r_hi))
        else $error("bisection interval empty");

    // a count is bumped only while a finished in-range item moves out
    a_inc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fsm_inc |=> (o_out_valid && o_in_range && !o_bin_full))
        else $error("count bumped without a matching result");

endmodule

// ----- sv/bbb_cell.sv -----
// bbb_cell: one boundary entry with its bin count and position compare
// depends on bbb_pkg
module bbb_cell #(
    parameter int POSITION_BITS = 32,
    parameter int SEL_BITS      = 6,
    parameter int INDEX         = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bbb_pkg::t_cell_cmd                i_cmd,
    input  logic [bbb_pkg::WIDX_BITS-1:0]     i_wr_idx,
    input  logic signed [POSITION_BITS-1:0]   i_wr_data,
    input  logic signed [POSITION_BITS-1:0]   i_pos,
    input  logic [SEL_BITS-1:0]               i_sel,
    output bbb_pkg::t_cell_flags              o_flags,
    output logic [bbb_pkg::COUNT_BITS-1:0]    o_count
);
    import bbb_pkg::*;

    logic signed [POSITION_BITS-1:0] r_bound;
    logic [COUNT_BITS-1:0]           r_count;
    t_cell_flags                     r_flags;
    logic                            w_wr_hit;
    logic                            w_sel_hit;

    assign w_wr_hit  = i_cmd.wr && (int'(i_wr_idx) == INDEX);
    assign w_sel_hit = (int'(i_sel) == INDEX);

    // boundary entry, undefined until written
    always_ff @(posedge i_clk) begin
        if (w_wr_hit) begin
            r_bound <= i_wr_data;
        end
    end

    // compare the broadcast position against this entry
    always_ff @(posedge i_clk) begin
        r_flags.ge <= (i_pos >= r_bound);
        r_flags.le <= (i_pos <= r_bound);
    end

    // bin count, cleared by reset and by a clear item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clr) begin
            r_count <= '0;
        end else if (i_cmd.inc && w_sel_hit) begin
            r_count <= r_count + COUNT_BITS'(1);
        end
    end

    assign o_flags = r_flags;
    assign o_count = r_count;

endmodule
